// ===== rtl/ahc_pkg.sv =====
// Shared constants, register codes and stage payload types for the altitude hold core.
package ahc_pkg;

	// Stream widths, padded to whole bytes
	localparam int IN_W  = 88;
	localparam int OUT_W = 32;

	// Control limits
	localparam int TILT_LIMIT    = 800;
	localparam int ALT_ERR_LIMIT = 500;
	localparam int ALT_DEADBAND  = 5;
	localparam int SETVEL_LIMIT  = 300;
	localparam int VEL_P_LIMIT   = 300;
	localparam int INTEG_LIMIT   = 8192 * 300;
	localparam int D_LIMIT       = 150;
	localparam int THR_LIMIT     = 750;

	// Power-of-two scalings of the gains
	localparam int ALT_P_SHIFT = 7;
	localparam int VEL_P_SHIFT = 5;
	localparam int VEL_I_SHIFT = 13;
	localparam int VEL_D_SHIFT = 9;

	// Gain reset values
	localparam logic [7:0] ALT_P_RST = 8'd50;
	localparam logic [7:0] VEL_P_RST = 8'd120;
	localparam logic [7:0] VEL_I_RST = 8'd45;
	localparam logic [7:0] VEL_D_RST = 8'd1;

	typedef enum logic [1:0] {
		REG_ALT_P = 2'd0,
		REG_VEL_P = 2'd1,
		REG_VEL_I = 2'd2,
		REG_VEL_D = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] alt_p;
		logic [7:0] vel_p;
		logic [7:0] vel_i;
		logic [7:0] vel_d;
	} gains_t;

	typedef struct packed {
		logic signed [15:0] est_altitude;
		logic signed [15:0] vert_velocity;
		logic signed [15:0] vert_accel;
		logic signed [11:0] roll_angle;
		logic signed [11:0] pitch_angle;
		logic               armed;
		logic               velocity_mode;
		logic signed [7:0]  stick_velocity;
		logic               capture_target;
	} in_item_t;

	typedef struct packed {
		logic               tilt;
		logic               armed;
		logic               velocity_mode;
		logic signed [7:0]  stick_velocity;
		logic signed [15:0] vert_velocity;
		logic signed [18:0] alt_prod;
		logic signed [16:0] accel_sum;
		logic signed [15:0] target;
	} s2_t;

	typedef struct packed {
		logic               tilt;
		logic               armed;
		logic signed [25:0] p_prod;
		logic signed [25:0] i_prod;
		logic signed [25:0] d_prod;
		logic signed [15:0] target;
	} s3_t;

	typedef struct packed {
		logic signed [10:0] throttle_adjust;
		logic signed [15:0] target_altitude;
	} res_t;

endpackage

// ===== rtl/ahc_front.sv =====
// Front stage: target capture, tilt check, altitude error and outer-loop product.
module ahc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  ahc_pkg::in_item_t item,
	input  logic [7:0]       alt_p_gain,
	output ahc_pkg::s2_t     st
);
	import ahc_pkg::*;

	logic signed [15:0] hold_q;
	logic signed [15:0] prev_accel_q;
	logic signed [15:0] cap_tgt;
	logic signed [15:0] new_tgt;
	logic               tilt;
	logic signed [16:0] diff;
	logic signed [9:0]  err_c;
	logic signed [9:0]  err_db;

	// Target selection and clamped, deadbanded altitude error
	always_comb begin
		cap_tgt = item.capture_target ? item.est_altitude : hold_q;
		tilt = (item.roll_angle >= TILT_LIMIT) || (item.roll_angle <= -TILT_LIMIT) ||
			(item.pitch_angle >= TILT_LIMIT) || (item.pitch_angle <= -TILT_LIMIT);
		new_tgt = (!tilt && !item.armed) ? item.est_altitude : cap_tgt;
		diff = 17'(new_tgt) - 17'(item.est_altitude);
		if (diff > ALT_ERR_LIMIT) begin
			err_c = 10'(ALT_ERR_LIMIT);
		end else if (diff < -ALT_ERR_LIMIT) begin
			err_c = 10'(-ALT_ERR_LIMIT);
		end else begin
			err_c = diff[9:0];
		end
		if (err_c > ALT_DEADBAND) begin
			err_db = err_c - 10'(ALT_DEADBAND);
		end else if (err_c < -ALT_DEADBAND) begin
			err_db = err_c + 10'(ALT_DEADBAND);
		end else begin
			err_db = '0;
		end
	end

	// Stage payload
	always_comb begin
		st.tilt           = tilt;
		st.armed          = item.armed;
		st.velocity_mode  = item.velocity_mode;
		st.stick_velocity = item.stick_velocity;
		st.vert_velocity  = item.vert_velocity;
		st.alt_prod       = 19'(signed'({1'b0, alt_p_gain})) * 19'(err_db);
		st.accel_sum      = 17'(item.vert_accel) + 17'(prev_accel_q);
		st.target         = new_tgt;
	end

	// Hold target and acceleration history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q       <= '0;
			prev_accel_q <= '0;
		end else if (en) begin
			hold_q       <= new_tgt;
			prev_accel_q <= item.vert_accel;
		end
	end

endmodule

// ===== rtl/ahc_mult.sv =====
// Middle stage: velocity setpoint, velocity error and inner-loop products.
module ahc_mult (
	input  ahc_pkg::s2_t   st2,
	input  ahc_pkg::gains_t gains,
	output ahc_pkg::s3_t   st3
);
	import ahc_pkg::*;

	localparam logic signed [18:0] ALT_BIAS = 19'((1 << ALT_P_SHIFT) - 1);

	logic signed [18:0] alt_q;
	logic signed [9:0]  setvel;
	logic signed [9:0]  sel_vel;
	logic signed [16:0] vel_err;

	// Outer loop scale (truncating toward zero) and clamp
	always_comb begin
		alt_q = (st2.alt_prod + (st2.alt_prod[18] ? ALT_BIAS : 19'sd0)) >>> ALT_P_SHIFT;
		if (alt_q > SETVEL_LIMIT) begin
			setvel = 10'(SETVEL_LIMIT);
		end else if (alt_q < -SETVEL_LIMIT) begin
			setvel = 10'(-SETVEL_LIMIT);
		end else begin
			setvel = alt_q[9:0];
		end
		sel_vel = st2.velocity_mode ? 10'(st2.stick_velocity) : setvel;
		vel_err = 17'(sel_vel) - 17'(st2.vert_velocity);
	end

	// Inner loop products
	always_comb begin
		st3.tilt   = st2.tilt;
		st3.armed  = st2.armed;
		st3.p_prod = 26'(signed'({1'b0, gains.vel_p})) * 26'(vel_err);
		st3.i_prod = 26'(signed'({1'b0, gains.vel_i})) * 26'(vel_err);
		st3.d_prod = 26'(signed'({1'b0, gains.vel_d})) * 26'(st2.accel_sum);
		st3.target = st2.target;
	end

endmodule

// ===== rtl/ahc_sum.sv =====
// Final stage: velocity integrator, term scaling and clamps, throttle sum.
module ahc_sum (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  ahc_pkg::s3_t  st3,
	output ahc_pkg::res_t res
);
	import ahc_pkg::*;

	localparam logic signed [25:0] P_BIAS = 26'((1 << VEL_P_SHIFT) - 1);
	localparam logic signed [22:0] I_BIAS = 23'((1 << VEL_I_SHIFT) - 1);
	localparam logic signed [25:0] D_BIAS = 26'((1 << VEL_D_SHIFT) - 1);

	logic signed [22:0] integ_q;
	logic signed [22:0] integ_new;
	logic signed [26:0] integ_sum;
	logic signed [25:0] p_q;
	logic signed [22:0] i_q;
	logic signed [25:0] d_q;
	logic signed [10:0] p_term;
	logic signed [10:0] i_term;
	logic signed [10:0] d_term;

	// Integrator update with clamp, cleared while disarmed
	always_comb begin
		integ_sum = 27'(integ_q) + 27'(st3.i_prod);
		if (!st3.armed) begin
			integ_new = '0;
		end else if (integ_sum > INTEG_LIMIT) begin
			integ_new = 23'(INTEG_LIMIT);
		end else if (integ_sum < -INTEG_LIMIT) begin
			integ_new = 23'(-INTEG_LIMIT);
		end else begin
			integ_new = integ_sum[22:0];
		end
	end

	// Term scaling, truncating toward zero, and clamps on the P and D terms
	always_comb begin
		p_q = (st3.p_prod + (st3.p_prod[25] ? P_BIAS : 26'sd0)) >>> VEL_P_SHIFT;
		i_q = (integ_new + (integ_new[22] ? I_BIAS : 23'sd0)) >>> VEL_I_SHIFT;
		d_q = (st3.d_prod + (st3.d_prod[25] ? D_BIAS : 26'sd0)) >>> VEL_D_SHIFT;
		if (p_q > VEL_P_LIMIT) begin
			p_term = 11'(VEL_P_LIMIT);
		end else if (p_q < -VEL_P_LIMIT) begin
			p_term = 11'(-VEL_P_LIMIT);
		end else begin
			p_term = p_q[10:0];
		end
		i_term = i_q[10:0];
		if (d_q > D_LIMIT) begin
			d_term = 11'(D_LIMIT);
		end else if (d_q < -D_LIMIT) begin
			d_term = 11'(-D_LIMIT);
		end else begin
			d_term = d_q[10:0];
		end
	end

	// Throttle sum; tilted ticks give no correction
	always_comb begin
		res.throttle_adjust = st3.tilt ? 11'sd0 : (p_term + i_term - d_term);
		res.target_altitude = st3.target;
	end

	// Integrator state, held on tilted ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (en && !st3.tilt) begin
			integ_q <= integ_new;
		end
	end

`ifndef NO_ASSERTIONS
	a_integ_range: assert property (@(posedge clk) disable iff (!arst_n)
		integ_q <= INTEG_LIMIT && integ_q >= -INTEG_LIMIT)
		else $error("integrator outside its limit");
	a_tilt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		en && st3.tilt |=> $stable(integ_q))
		else $error("integrator moved on a tilted tick");
	a_disarm_clear: assert property (@(posedge clk) disable iff (!arst_n)
		en && !st3.tilt && !st3.armed |=> integ_q == 23'sd0)
		else $error("integrator not cleared while disarmed");
	a_thr_range: assert property (@(posedge clk) disable iff (!arst_n)
		en |-> res.throttle_adjust <= THR_LIMIT && res.throttle_adjust >= -THR_LIMIT)
		else $error("throttle correction out of range");
`endif

endmodule

// ===== rtl/altitude_hold_cascade_pid_core.sv =====
// Top level: stream ports, gain registers, pipeline registers and result register.
// A request's valid bit passes v_s1, v_s2 and v_s3 in turn, then out_valid_q, which drives m_tvalid.
// Throughput: one request per cycle; the four-register pipeline (input, two
// product stages, result) advances as a whole whenever the result register is
// empty or being taken, so m_tready low stalls every stage.
// Reset: arst_n clears the valid bits, hold target, integrator, acceleration
// history and restores the gain registers to their defaults.
module altitude_hold_cascade_pid_core (
	input  logic                      clk,
	input  logic                      arst_n,
	// est_altitude[15:0], vert_velocity[31:16], vert_accel[47:32], roll_angle[59:48],
	// pitch_angle[71:60], armed[72], velocity_mode[73], stick_velocity[81:74],
	// capture_target[82], zero[87:83]
	input  logic [ahc_pkg::IN_W-1:0]  s_tdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// throttle_adjust[10:0], target_altitude[26:11], zero[31:27]
	output logic [ahc_pkg::OUT_W-1:0] m_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_idx,
	input  logic [7:0]                cfg_data
);
	import ahc_pkg::*;

	gains_t   gains_q;
	in_item_t item_in;
	in_item_t item_s1;
	s2_t      st2_c;
	s2_t      st2_s2;
	s3_t      st3_c;
	s3_t      st3_s3;
	res_t     res_c;
	logic     v_s1, v_s2, v_s3, out_valid_q;
	logic     adv;
	logic [OUT_W-1:0] out_data_q;

	// Whole pipe advances when the result register can take a new entry
	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Unpack input request
	always_comb begin
		item_in.est_altitude   = s_tdata[15:0];
		item_in.vert_velocity  = s_tdata[31:16];
		item_in.vert_accel     = s_tdata[47:32];
		item_in.roll_angle     = s_tdata[59:48];
		item_in.pitch_angle    = s_tdata[71:60];
		item_in.armed          = s_tdata[72];
		item_in.velocity_mode  = s_tdata[73];
		item_in.stick_velocity = s_tdata[81:74];
		item_in.capture_target = s_tdata[82];
	end

	// Gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.alt_p <= ALT_P_RST;
			gains_q.vel_p <= VEL_P_RST;
			gains_q.vel_i <= VEL_I_RST;
			gains_q.vel_d <= VEL_D_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_ALT_P: gains_q.alt_p <= cfg_data;
				REG_VEL_P: gains_q.vel_p <= cfg_data;
				REG_VEL_I: gains_q.vel_i <= cfg_data;
				REG_VEL_D: gains_q.vel_d <= cfg_data;
				default:   gains_q <= gains_q;
			endcase
		end
	end

	ahc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv && v_s1),
		.item       (item_s1),
		.alt_p_gain (gains_q.alt_p),
		.st         (st2_c)
	);

	ahc_mult u_mult (
		.st2   (st2_s2),
		.gains (gains_q),
		.st3   (st3_c)
	);

	ahc_sum u_sum (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv && v_s3),
		.st3    (st3_s3),
		.res    (res_c)
	);

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= s_tvalid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1    <= item_in;
			st2_s2     <= st2_c;
			st3_s3     <= st3_c;
			out_data_q <= {5'd0, res_c.target_altitude, res_c.throttle_adjust};
		end
	end

endmodule
